@@ sv/tlrq_pkg.sv @@
`timescale 1ns / 1ps
package tlrq_pkg;

  localparam int ENTRIES = 64;
  localparam int ID_W    = 6;
  localparam int LVL_W   = 2;
  localparam int PRIO_W  = 4;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 2;
  localparam int CNT_W   = $clog2(ENTRIES);

  localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(3);
  localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_ENQ     = 3'd1,
    CMD_PICK    = 3'd2,
    CMD_SETPRIO = 3'd3,
    CMD_BOOST   = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_BACK,
    OP_FRONT,
    OP_SORTED,
    OP_REMOVE,
    OP_HOLE,
    OP_COMPACT,
    OP_BOOST,
    OP_SETPRIO
  } cell_opc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COMPACT,
    S_INSERT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              v;
    logic [ID_W-1:0]   id;
    logic [LVL_W-1:0]  lvl;
    logic [PRIO_W-1:0] prio;
  } cell_data_t;

  typedef struct packed {
    cell_opc_t         op;
    logic [ID_W-1:0]   key_id;
    logic [LVL_W-1:0]  key_lvl;
    logic [PRIO_W-1:0] key_prio;
    logic [ID_W-1:0]   new_id;
    logic [LVL_W-1:0]  new_lvl;
    logic [PRIO_W-1:0] new_prio;
    logic [PRIO_W-1:0] boost_prio;
  } cell_op_t;

  typedef struct packed {
    logic cond;
    logic head;
    logic hit_id;
    logic hit_l2;
    logic hit_lvl;
  } cell_stat_t;

endpackage

@@ sv/tlrq_cell.sv @@
`timescale 1ns / 1ps
module tlrq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tlrq_pkg::cell_op_t   op,
  input  tlrq_pkg::cell_data_t left,
  input  logic                left_cond,
  input  tlrq_pkg::cell_data_t right,
  output tlrq_pkg::cell_data_t data,
  output tlrq_pkg::cell_stat_t stat
);
  import tlrq_pkg::*;

  cell_data_t data_r, data_nxt;
  logic       cond;

  assign data = data_r;

  always_comb begin
    case (op.op)
      OP_BACK:   cond = !data_r.v || (data_r.lvl > op.key_lvl);
      OP_FRONT:  cond = !data_r.v || (data_r.lvl >= op.key_lvl);
      // level 2 may be out of order after front inserts: stop at the first larger priority
      OP_SORTED: cond = left_cond || !data_r.v ||
                        (data_r.lvl == LVL_TOP && data_r.prio > op.key_prio);
      OP_REMOVE: cond = data_r.v && (data_r.lvl >= op.key_lvl);
      default:   cond = 1'b0;
    endcase
  end

  always_comb begin
    stat.cond    = cond;
    stat.head    = cond && !left_cond;
    stat.hit_id  = data_r.v && (data_r.id == op.key_id);
    stat.hit_l2  = stat.hit_id && (data_r.lvl == LVL_TOP);
    stat.hit_lvl = data_r.v && (data_r.lvl == op.key_lvl);
  end

  always_comb begin
    data_nxt = data_r;
    case (op.op)
      OP_BACK, OP_FRONT, OP_SORTED: begin
        if (left_cond) begin
          data_nxt = left;
        end else if (cond) begin
          data_nxt = '{v: 1'b1, id: op.new_id, lvl: op.new_lvl, prio: op.new_prio};
        end
      end
      OP_REMOVE: begin
        if (cond) data_nxt = right;
      end
      OP_HOLE: begin
        if (stat.hit_id) data_nxt.v = 1'b0;
      end
      OP_COMPACT: begin
        if (!data_r.v && right.v) begin
          data_nxt = right;
        end else if (!left.v && data_r.v) begin
          data_nxt.v = 1'b0;
        end
      end
      OP_BOOST: begin
        if (data_r.v) begin
          data_nxt.lvl  = '0;
          data_nxt.prio = op.boost_prio;
        end
      end
      OP_SETPRIO: begin
        if (stat.hit_id) data_nxt.prio = op.key_prio;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ sv/three_level_ready_queue_top.sv @@
`timescale 1ns / 1ps
// Three-level ready queue. Commands enter on the in_ channel (valid/ready);
// every command gives one result on the out_ channel (valid/ready).
// The queues live in a row of ENTRIES cells, ordered level 0, level 1,
// level 2 (priority sorted); inserts and removals shift the whole row together.
// One command is worked at a time. Each command passes the execute state, then
// the done state, which loads the output register; set priority of a queued
// level-2 entry puts a compaction sweep of the row and an insert state
// between the two. A new command is taken once the previous one reaches the
// output register, even while that result still waits for out_ready; a stalled
// receiver then holds the block after that one further command.
// cfg_wr_en writes boost_priority at once; write only while idle.
// Reset (synchronous, rst_n low) empties all queues, selects level 0,
// sets boost_priority and every entry priority to 3. No clearing pass.
module three_level_ready_queue_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tlrq_pkg::CMD_W-1:0]  in_command,
  input  logic [tlrq_pkg::ID_W-1:0]   in_entry_id,
  input  logic [tlrq_pkg::LVL_W-1:0]  in_queue_level,
  input  logic                        in_front_insert,
  input  logic [tlrq_pkg::PRIO_W-1:0] in_new_priority,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tlrq_pkg::ID_W-1:0]   out_picked_entry,
  output logic                        out_picked_valid,
  output logic [tlrq_pkg::LVL_W-1:0]  out_serve_level,
  output logic [tlrq_pkg::ST_W-1:0]   out_status,
  input  logic                        cfg_wr_en,
  input  logic [tlrq_pkg::PRIO_W-1:0] cfg_wr_data
);
  import tlrq_pkg::*;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [LVL_W-1:0]  lv_r;
  logic              front_r;
  logic [PRIO_W-1:0] prio_r;
  logic [PRIO_W-1:0] rd_r;
  logic              rdv_r;
  logic [LVL_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PRIO_W-1:0] boost_r;
  logic [ENTRIES-1:0] pv_r;
  logic [PRIO_W-1:0] prio_mem [ENTRIES];

  logic              res_pv_r, res_pv_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  status_t           res_st_r, res_st_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r;
  logic              out_pv_r;
  logic [LVL_W-1:0]  out_lvl_r;
  status_t           out_st_r;

  logic              mem_we;
  logic [ID_W-1:0]   mem_wa;
  logic [PRIO_W-1:0] mem_wd;

  cell_op_t          cop;
  cell_data_t        cdat [ENTRIES];
  cell_stat_t        cst  [ENTRIES];
  logic              any_id, any_l2, any_lvl;
  logic [ID_W-1:0]   head_id;
  logic [PRIO_W-1:0] head_prio;
  logic [PRIO_W-1:0] eff_prio;
  logic              accept;

  localparam cell_data_t LEFT_EDGE  = '{v: 1'b1, id: '0, lvl: '0, prio: '0};
  localparam cell_data_t RIGHT_EDGE = '0;

  assign in_ready         = (state_r == S_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_picked_entry = out_id_r;
  assign out_picked_valid = out_pv_r;
  assign out_serve_level  = out_lvl_r;
  assign out_status       = out_st_r;
  assign eff_prio         = rdv_r ? rd_r : PRIO_RESET;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_first
      tlrq_cell u_cell (
        .clk(clk), .rst_n(rst_n), .op(cop),
        .left(LEFT_EDGE), .left_cond(1'b0),
        .right(cdat[g+1]), .data(cdat[g]), .stat(cst[g])
      );
    end else if (g == ENTRIES - 1) begin : g_last
      tlrq_cell u_cell (
        .clk(clk), .rst_n(rst_n), .op(cop),
        .left(cdat[g-1]), .left_cond(cst[g-1].cond),
        .right(RIGHT_EDGE), .data(cdat[g]), .stat(cst[g])
      );
    end else begin : g_mid
      tlrq_cell u_cell (
        .clk(clk), .rst_n(rst_n), .op(cop),
        .left(cdat[g-1]), .left_cond(cst[g-1].cond),
        .right(cdat[g+1]), .data(cdat[g]), .stat(cst[g])
      );
    end
  end

  always_comb begin
    any_id    = 1'b0;
    any_l2    = 1'b0;
    any_lvl   = 1'b0;
    head_id   = '0;
    head_prio = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_id    = any_id  | cst[i].hit_id;
      any_l2    = any_l2  | cst[i].hit_l2;
      any_lvl   = any_lvl | cst[i].hit_lvl;
      head_id   = head_id   | (cdat[i].id   & {ID_W{cst[i].head}});
      head_prio = head_prio | (cdat[i].prio & {PRIO_W{cst[i].head}});
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    res_pv_nxt = res_pv_r;
    res_id_nxt = res_id_r;
    res_st_nxt = res_st_r;
    mem_we     = 1'b0;
    mem_wa     = id_r;
    mem_wd     = prio_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cop.op         = OP_NOP;
    cop.key_id     = id_r;
    cop.key_lvl    = (cmd_r == CMD_PICK) ? cur_r : lv_r;
    cop.key_prio   = prio_r;
    cop.new_id     = id_r;
    cop.new_lvl    = lv_r;
    cop.new_prio   = prio_r;
    cop.boost_prio = boost_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_EXEC;
          res_pv_nxt = 1'b0;
          res_id_nxt = '0;
          res_st_nxt = ST_DONE;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_INIT: begin
            if (any_id) begin
              res_st_nxt = ST_REJECT;
            end else begin
              mem_we = 1'b1;
              mem_wd = boost_r;
            end
          end
          CMD_ENQ: begin
            if (any_id) begin
              res_st_nxt = ST_REJECT;
            end else begin
              cop.new_prio = eff_prio;
              cop.key_prio = eff_prio;
              if (front_r)             cop.op = OP_FRONT;
              else if (lv_r == LVL_TOP) cop.op = OP_SORTED;
              else                      cop.op = OP_BACK;
            end
          end
          CMD_PICK: begin
            if (any_lvl) begin
              cop.op     = OP_REMOVE;
              res_pv_nxt = 1'b1;
              res_id_nxt = head_id;
              mem_we     = 1'b1;
              mem_wa     = head_id;
              mem_wd     = head_prio;
            end else begin
              res_st_nxt = ST_EMPTY;
              cur_nxt    = (cur_r == LVL_TOP) ? '0 : cur_r + LVL_W'(1);
            end
          end
          CMD_SETPRIO: begin
            mem_we = 1'b1;
            if (any_l2) begin
              cop.op    = OP_HOLE;
              cnt_nxt   = '0;
              state_nxt = S_COMPACT;
            end else if (any_id) begin
              cop.op = OP_SETPRIO;
            end
          end
          CMD_BOOST: cop.op = OP_BOOST;
          default: ;
        endcase
      end
      S_COMPACT: begin
        cop.op  = OP_COMPACT;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ENTRIES - 1)) state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cop.op      = OP_SORTED;
        cop.new_lvl = LVL_TOP;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      boost_r     <= PRIO_RESET;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) boost_r <= cfg_wr_data;
      if (mem_we) pv_r[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    res_pv_r <= res_pv_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    if (accept) begin
      cmd_r   <= cmd_t'(in_command);
      id_r    <= in_entry_id;
      lv_r    <= (in_queue_level > LVL_TOP) ? LVL_TOP : in_queue_level;
      front_r <= in_front_insert;
      prio_r  <= in_new_priority;
      rdv_r   <= pv_r[in_entry_id];
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_id_r  <= res_id_r;
      out_pv_r  <= res_pv_r;
      out_lvl_r <= cur_r;
      out_st_r  <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) prio_mem[mem_wa] <= mem_wd;
    if (accept) rd_r <= prio_mem[in_entry_id];
  end

endmodule

@@ tb/tb_three_level_ready_queue_top.sv @@
`timescale 1ns / 1ps
module tb_three_level_ready_queue_top;
  import tlrq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [6:0] NIL = 7'(ENTRIES);
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [ID_W-1:0]  entry;
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [ST_W-1:0]  status;
  } sched_res_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [LVL_W-1:0]  lvl;
    logic              front;
    logic [PRIO_W-1:0] prio;
    logic              typed;
    sched_res_t        want;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [CMD_W-1:0] in_command;
  logic [ID_W-1:0] in_entry_id;
  logic [LVL_W-1:0] in_queue_level;
  logic in_front_insert;
  logic [PRIO_W-1:0] in_new_priority;
  logic out_valid, out_ready;
  logic [ID_W-1:0] out_picked_entry;
  logic out_picked_valid;
  logic [LVL_W-1:0] out_serve_level;
  logic [ST_W-1:0] out_status;
  logic cfg_wr_en;
  logic [PRIO_W-1:0] cfg_wr_data;

  three_level_ready_queue_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_entry_id(in_entry_id),
    .in_queue_level(in_queue_level), .in_front_insert(in_front_insert),
    .in_new_priority(in_new_priority),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_picked_entry(out_picked_entry), .out_picked_valid(out_picked_valid),
    .out_serve_level(out_serve_level), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // scheduler shadow state
  logic [6:0] link_of[ENTRIES];
  logic [PRIO_W-1:0] prio_of[ENTRIES];
  logic [LVL_W-1:0] level_of[ENTRIES];
  bit queued_of[ENTRIES];
  logic [6:0] head_of[3], tail_of[3];
  logic [LVL_W-1:0] serve_lvl;
  logic [PRIO_W-1:0] boost_prio;

  sched_res_t pending_results[$];
  int errors, mismatches, accepted, delivered, picks, empties, rejects;
  int send_idle_pct, recv_stall_pct;
  bit hold_req;
  int hold_left;
  bit moved;

  function automatic void sched_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      link_of[i] = '0;
      prio_of[i] = PRIO_RESET;
      level_of[i] = '0;
      queued_of[i] = 0;
    end
    for (int l = 0; l < 3; l++) begin
      head_of[l] = NIL;
      tail_of[l] = NIL;
    end
    serve_lvl = '0;
    boost_prio = PRIO_RESET;
  endfunction

  function automatic void link_sorted(logic [6:0] e);
    logic [6:0] prv = NIL, c = head_of[2];
    int n = 0;
    while (c < NIL && n < ENTRIES && prio_of[c] <= prio_of[e]) begin
      prv = c;
      c = link_of[c];
      n++;
    end
    if (c >= NIL) c = NIL;
    link_of[e] = c;
    if (prv < NIL) link_of[prv] = e;
    else head_of[2] = e;
    if (c == NIL) tail_of[2] = e;
  endfunction

  function automatic void unlink_top(logic [6:0] e);
    logic [6:0] prv = NIL, c = head_of[2];
    int n = 0;
    while (c < NIL && c != e && n < ENTRIES) begin
      prv = c;
      c = link_of[c];
      n++;
    end
    if (c != e) return;
    if (prv < NIL) link_of[prv] = link_of[e];
    else head_of[2] = link_of[e];
    if (tail_of[2] == e) tail_of[2] = prv;
    link_of[e] = NIL;
  endfunction

  function automatic void join_level(int dst, int src);
    if (head_of[src] >= NIL) return;
    if (tail_of[dst] < NIL) link_of[tail_of[dst]] = head_of[src];
    else head_of[dst] = head_of[src];
    tail_of[dst] = tail_of[src];
    head_of[src] = NIL;
    tail_of[src] = NIL;
  endfunction

  function automatic sched_res_t sched_apply(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                             logic [LVL_W-1:0] lv_in, logic fr,
                                             logic [PRIO_W-1:0] p);
    sched_res_t r = '0;
    logic [6:0] e = 7'(id), h;
    int lv = (lv_in > LVL_TOP) ? 2 : int'(lv_in);
    int cl;
    r.status = ST_DONE;
    case (c)
      CMD_INIT: begin
        if (queued_of[e]) r.status = ST_REJECT;
        else begin
          prio_of[e] = boost_prio;
          level_of[e] = '0;
        end
      end
      CMD_ENQ: begin
        if (queued_of[e]) r.status = ST_REJECT;
        else begin
          level_of[e] = LVL_W'(lv);
          queued_of[e] = 1;
          if (fr) begin
            link_of[e] = head_of[lv];
            if (head_of[lv] >= NIL) tail_of[lv] = e;
            head_of[lv] = e;
          end else if (lv == 2) link_sorted(e);
          else begin
            link_of[e] = NIL;
            if (tail_of[lv] >= NIL) head_of[lv] = e;
            else link_of[tail_of[lv]] = e;
            tail_of[lv] = e;
          end
        end
      end
      CMD_SETPRIO: begin
        prio_of[e] = p;
        if (queued_of[e] && level_of[e] == LVL_TOP) begin
          unlink_top(e);
          link_sorted(e);
        end
      end
      CMD_PICK: begin
        cl = int'(serve_lvl);
        h = head_of[cl];
        if (h < NIL) begin
          head_of[cl] = link_of[h];
          if (head_of[cl] >= NIL) begin
            head_of[cl] = NIL;
            tail_of[cl] = NIL;
          end
          link_of[h] = NIL;
          queued_of[h] = 0;
          r.entry = h[ID_W-1:0];
          r.valid = 1;
        end else begin
          r.status = ST_EMPTY;
          serve_lvl = (cl <= 1) ? LVL_W'(cl + 1) : '0;
        end
      end
      CMD_BOOST: begin
        for (int i = 0; i < ENTRIES; i++)
          if (queued_of[i]) begin
            level_of[i] = '0;
            prio_of[i] = boost_prio;
          end
        join_level(1, 2);
        join_level(0, 1);
      end
      default: ;
    endcase
    r.level = serve_lvl;
    return r;
  endfunction

  task automatic send_cmd(logic [CMD_W-1:0] c, logic [ID_W-1:0] id, logic [LVL_W-1:0] lv,
                          logic fr, logic [PRIO_W-1:0] p, logic typed, sched_res_t want);
    sched_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= c;
    in_entry_id <= id;
    in_queue_level <= lv;
    in_front_insert <= fr;
    in_new_priority <= p;
    do @(posedge clk); while (!in_ready);
    r = sched_apply(c, id, lv, fr, p);
    pending_results.push_back(typed ? want : r);
    accepted++;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_boost(logic [PRIO_W-1:0] v);
    drain_results();
    cfg_wr_data <= v;
    cfg_wr_en <= 1;
    @(posedge clk);
    cfg_wr_en <= 0;
    boost_prio = v;
    @(posedge clk);
  endtask

  task automatic send_random();
    int k = $urandom_range(99);
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0] id;
    if (k < 8) c = CMD_INIT;
    else if (k < 45) c = CMD_ENQ;
    else if (k < 80) c = CMD_PICK;
    else if (k < 90) c = CMD_SETPRIO;
    else if (k < 96) c = CMD_BOOST;
    else c = CMD_W'($urandom_range(7, 5));
    id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(63)) : ID_W'($urandom_range(15));
    send_cmd(c, id, LVL_W'($urandom_range(3)), $urandom_range(4) == 0,
             PRIO_W'($urandom_range(15)), 0, '0);
  endtask

  // receiver and result check
  always @(posedge clk) begin
    sched_res_t w;
    if (rst_n && out_valid && out_ready) begin
      delivered++;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        w = pending_results.pop_front();
        if (out_picked_valid) picks++;
        if (out_status == ST_EMPTY) empties++;
        if (out_status == ST_REJECT) rejects++;
        if (out_picked_entry !== w.entry || out_picked_valid !== w.valid ||
            out_serve_level !== w.level || out_status !== w.status) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch at %0t: exp entry=%0d valid=%0d level=%0d status=%0d, got %0d %0d %0d %0d",
                     $realtime, w.entry, w.valid, w.level, w.status, out_picked_entry,
                     out_picked_valid, out_serve_level, out_status);
        end
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transfer
  int idle_cycles;
  always @(posedge clk) begin
    moved = (in_valid && in_ready) || (out_valid && out_ready);
    if (!rst_n || moved) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  stim_row_t directed[] = '{
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b1, '{6'd0, 1'b0, 2'd1, ST_EMPTY}},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b1, '{6'd0, 1'b0, 2'd2, ST_EMPTY}},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b1, '{6'd0, 1'b0, 2'd0, ST_EMPTY}},
    '{CMD_ENQ, 6'd63, 2'd0, 1'b0, 4'd15, 1'b1, '{6'd0, 1'b0, 2'd0, ST_DONE}},
    '{CMD_ENQ, 6'd63, 2'd1, 1'b1, 4'd0, 1'b1, '{6'd0, 1'b0, 2'd0, ST_REJECT}},
    '{CMD_INIT, 6'd63, 2'd0, 1'b0, 4'd0, 1'b1, '{6'd0, 1'b0, 2'd0, ST_REJECT}},
    '{CMD_ENQ, 6'd0, 2'd3, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_ENQ, 6'd5, 2'd2, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_SETPRIO, 6'd5, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_SETPRIO, 6'd0, 2'd0, 1'b0, 4'd15, 1'b0, '0},
    '{CMD_ENQ, 6'd7, 2'd2, 1'b1, 4'd0, 1'b0, '0},
    '{CMD_ENQ, 6'd9, 2'd1, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_ENQ, 6'd10, 2'd1, 1'b1, 4'd0, 1'b0, '0},
    '{CMD_INIT, 6'd20, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_SETPRIO, 6'd21, 2'd3, 1'b1, 4'd9, 1'b0, '0},
    '{CMD_UNUSED, 6'd42, 2'd3, 1'b1, 4'd15, 1'b1, '{6'd0, 1'b0, 2'd0, ST_DONE}},
    '{CMD_BOOST, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0},
    '{CMD_PICK, 6'd0, 2'd0, 1'b0, 4'd0, 1'b0, '0}
  };

  initial begin
    int phase_idle[4] = '{0, 84, 0, 29};
    int phase_stall[4] = '{0, 0, 84, 29};
    logic [PRIO_W-1:0] phase_boost[4];
    rst_n <= 0;
    in_valid <= 0;
    in_command <= '0;
    in_entry_id <= '0;
    in_queue_level <= '0;
    in_front_insert <= 0;
    in_new_priority <= '0;
    out_ready <= 0;
    cfg_wr_en <= 0;
    cfg_wr_data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    sched_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i])
      send_cmd(directed[i].cmd, directed[i].id, directed[i].lvl, directed[i].front,
               directed[i].prio, directed[i].typed, directed[i].want);

    phase_boost = '{4'd0, 4'd15, PRIO_W'($urandom_range(15)), PRIO_W'($urandom_range(15))};
    for (int ph = 0; ph < 4; ph++) begin
      write_boost(phase_boost[ph]);
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int n = 0; n < 356; n++) begin
        if (ph == 0 && n == 100) hold_req = 1;
        if (ph == 3 && n == 150) drain_results();
        send_random();
      end
    end

    drain_results();
    $display("%0d commands transferred, %0d results checked: %0d picks, %0d empty levels, %0d rejects",
             accepted, delivered, picks, empties, rejects);
    $display("boost priority settings 0, 15 and two random values; four idle/stall mixes");
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ three_level_ready_queue_top.f @@
sv/tlrq_pkg.sv
sv/tlrq_cell.sv
sv/three_level_ready_queue_top.sv
tb/tb_three_level_ready_queue_top.sv
